/* hdl/i2cmws_pkg.sv */
// Package for the I2C master write/read sequencer: word types, status codes
// and default sizes. No dependencies.
`timescale 1ns / 1ps

package i2cmws_pkg;

   localparam int TX_DEPTH_DEFAULT = 16;
   localparam int RX_MAX_DEFAULT   = 32;

   localparam logic [7:0] SLAVE_ADDR_RESET = 8'h3A;

   // request modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_EVENT = 2'd2;

   // acknowledge actions
   localparam logic [1:0] ACK_KEEP    = 2'd0;
   localparam logic [1:0] ACK_ENABLE  = 2'd1;
   localparam logic [1:0] ACK_DISABLE = 2'd2;

   // controller status codes
   localparam logic [7:0] ST_START         = 8'h08;
   localparam logic [7:0] ST_RESTART       = 8'h10;
   localparam logic [7:0] ST_WADDR_ACK     = 8'h18;
   localparam logic [7:0] ST_WADDR_NACK    = 8'h20;
   localparam logic [7:0] ST_WDATA_ACK     = 8'h28;
   localparam logic [7:0] ST_WDATA_NACK    = 8'h30;
   localparam logic [7:0] ST_ARB_LOST      = 8'h38;
   localparam logic [7:0] ST_RADDR_ACK     = 8'h40;
   localparam logic [7:0] ST_RADDR_NACK    = 8'h48;
   localparam logic [7:0] ST_RDATA_ACK     = 8'h50;
   localparam logic [7:0] ST_RDATA_NACK    = 8'h58;

   typedef enum logic {
      PH_IDLE,
      PH_ACTIVE
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] status_code;
      logic [7:0] bus_data;
      logic [3:0] buffer_index;
      logic [4:0] tx_count;
      logic [5:0] rx_count;
   } req_type;

   typedef struct packed {
      logic       data_write_valid;
      logic [7:0] data_byte;
      logic       set_start;
      logic       clear_start;
      logic       send_stop;
      logic [1:0] ack_action;
      logic       clear_interrupt;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [4:0] rx_index;
      logic       done_res;
   } rsp_type;

   // word handed from the sequencer to the output stage
   typedef struct packed {
      logic    valid;
      logic    use_mem;   // data_byte comes from the transmit buffer read
      rsp_type rsp;
   } stage_type;

endpackage

/* hdl/i2cmws_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module i2cmws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/i2cmws_ctrl.sv */
// Sequencer control: phase, counters, address register and status decode.
// Depends on i2cmws_pkg; drives the transmit buffer RAM ports.
`timescale 1ns / 1ps

module i2cmws_ctrl #(
   parameter int TX_DEPTH = i2cmws_pkg::TX_DEPTH_DEFAULT,
   parameter int RX_MAX   = i2cmws_pkg::RX_MAX_DEFAULT,
   localparam int AW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1,
   localparam int TPW = $clog2(TX_DEPTH + 1),
   localparam int RPW = $clog2(RX_MAX + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  i2cmws_pkg::req_type   req,
   input  logic                  csr_we,
   input  logic [7:0]            csr_data,
   output logic                  ram_wr_en,
   output logic [AW-1:0]         ram_wr_addr,
   output logic [7:0]            ram_wr_data,
   output logic                  ram_rd_en,
   output logic [AW-1:0]         ram_rd_addr,
   output i2cmws_pkg::stage_type s0
);

   i2cmws_pkg::phase_type phase_ff, phase_in;

   logic [7:0]     slave_addr_ff;
   logic [TPW-1:0] tx_pos_ff,  tx_pos_in;
   logic [TPW-1:0] tx_left_ff, tx_left_in;
   logic [RPW-1:0] rx_left_ff, rx_left_in;
   logic [RPW-1:0] rx_pos_ff,  rx_pos_in;
   logic           read_dir_ff, read_dir_in;

   logic is_event;
   logic write_ack_code;
   logic finish;

   assign is_event = accept && (req.mode == i2cmws_pkg::MODE_EVENT)
                     && (phase_ff == i2cmws_pkg::PH_ACTIVE);

   assign write_ack_code = (req.status_code == i2cmws_pkg::ST_WADDR_ACK)
                        || (req.status_code == i2cmws_pkg::ST_WADDR_NACK)
                        || (req.status_code == i2cmws_pkg::ST_WDATA_ACK)
                        || (req.status_code == i2cmws_pkg::ST_WDATA_NACK);

   // transfer ends on a NACKed last read byte, or write-only with all sent
   assign finish = is_event
                   && ((req.status_code == i2cmws_pkg::ST_RDATA_NACK)
                       || (write_ack_code && (tx_left_ff == '0) && (rx_left_ff == '0)));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && (req.mode == i2cmws_pkg::MODE_START)) begin
         phase_in = i2cmws_pkg::PH_ACTIVE;
      end else if (finish) begin
         phase_in = i2cmws_pkg::PH_IDLE;
      end
   end

   // counters, buffer access and result word
   always_comb begin
      tx_pos_in   = tx_pos_ff;
      tx_left_in  = tx_left_ff;
      rx_left_in  = rx_left_ff;
      rx_pos_in   = rx_pos_ff;
      read_dir_in = read_dir_ff;
      s0          = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(req.buffer_index);
      ram_wr_data = req.bus_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(tx_pos_ff);

      if (accept) begin
         case (req.mode)
            i2cmws_pkg::MODE_LOAD: begin
               ram_wr_en = (32'(req.buffer_index) < 32'(TX_DEPTH));
            end
            i2cmws_pkg::MODE_START: begin
               tx_left_in  = (32'(req.tx_count) > 32'(TX_DEPTH)) ?
                             TPW'(TX_DEPTH) : TPW'(req.tx_count);
               rx_left_in  = (32'(req.rx_count) > 32'(RX_MAX)) ?
                             RPW'(RX_MAX) : RPW'(req.rx_count);
               tx_pos_in   = '0;
               rx_pos_in   = '0;
               read_dir_in = 1'b0;
               s0.valid    = 1'b1;
               s0.rsp.set_start = 1'b1;
            end
            i2cmws_pkg::MODE_EVENT: begin
               if (phase_ff == i2cmws_pkg::PH_ACTIVE) begin
                  s0.valid = 1'b1;
                  s0.rsp.clear_interrupt = 1'b1;
                  case (req.status_code)
                     i2cmws_pkg::ST_START, i2cmws_pkg::ST_RESTART: begin
                        s0.rsp.data_write_valid = 1'b1;
                        s0.rsp.data_byte = slave_addr_ff | {7'd0, read_dir_ff};
                     end
                     i2cmws_pkg::ST_WADDR_ACK, i2cmws_pkg::ST_WADDR_NACK,
                     i2cmws_pkg::ST_WDATA_ACK, i2cmws_pkg::ST_WDATA_NACK: begin
                        if (tx_left_ff != '0) begin
                           s0.rsp.data_write_valid = 1'b1;
                           s0.use_mem = 1'b1;
                           ram_rd_en  = 1'b1;
                           tx_pos_in  = tx_pos_ff + 1'b1;
                           tx_left_in = tx_left_ff - 1'b1;
                           s0.rsp.clear_start = 1'b1;
                        end else if (rx_left_ff == '0) begin
                           s0.rsp.send_stop   = 1'b1;
                           s0.rsp.clear_start = 1'b1;
                           s0.rsp.done_res    = 1'b1;
                        end else begin
                           read_dir_in = ~read_dir_ff;
                           tx_pos_in   = '0;
                           rx_pos_in   = '0;
                           s0.rsp.set_start = 1'b1;
                        end
                     end
                     i2cmws_pkg::ST_ARB_LOST, i2cmws_pkg::ST_RADDR_NACK: begin
                        s0.rsp.set_start = 1'b1;
                     end
                     i2cmws_pkg::ST_RADDR_ACK: begin
                        s0.rsp.ack_action = (rx_left_ff != '0) ?
                                            i2cmws_pkg::ACK_ENABLE : i2cmws_pkg::ACK_DISABLE;
                        s0.rsp.clear_start = 1'b1;
                     end
                     i2cmws_pkg::ST_RDATA_ACK: begin
                        if (rx_left_ff != '0) begin
                           s0.rsp.rx_valid = 1'b1;
                           s0.rsp.rx_byte  = req.bus_data;
                           s0.rsp.rx_index = 5'(rx_pos_ff);
                           rx_pos_in  = rx_pos_ff + 1'b1;
                           rx_left_in = rx_left_ff - 1'b1;
                        end
                        s0.rsp.ack_action = (rx_left_in != '0) ?
                                            i2cmws_pkg::ACK_ENABLE : i2cmws_pkg::ACK_DISABLE;
                        s0.rsp.clear_start = 1'b1;
                     end
                     i2cmws_pkg::ST_RDATA_NACK: begin
                        s0.rsp.clear_start = 1'b1;
                        s0.rsp.send_stop   = 1'b1;
                        s0.rsp.done_res    = 1'b1;
                     end
                     default: begin
                        s0 = '0;
                     end
                  endcase
               end
            end
            default: begin
               s0 = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cmws_pkg::PH_IDLE;
         slave_addr_ff <= i2cmws_pkg::SLAVE_ADDR_RESET;
         tx_pos_ff     <= '0;
         tx_left_ff    <= '0;
         rx_left_ff    <= '0;
         rx_pos_ff     <= '0;
         read_dir_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         tx_pos_ff   <= tx_pos_in;
         tx_left_ff  <= tx_left_in;
         rx_left_ff  <= rx_left_in;
         rx_pos_ff   <= rx_pos_in;
         read_dir_ff <= read_dir_in;
         if (csr_we) begin
            slave_addr_ff <= csr_data;
         end
      end
   end

endmodule

/* hdl/i2cmws_out.sv */
// Output side: holds a word while the buffer read completes, then a result
// register towards the consumer. Depends on i2cmws_pkg.
`timescale 1ns / 1ps

module i2cmws_out (
   input  logic                  clock,
   input  logic                  reset,
   input  i2cmws_pkg::stage_type s0,
   input  logic [7:0]            rd_data,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output i2cmws_pkg::rsp_type   rsp_payload
);

   logic                  s1_valid_ff;
   i2cmws_pkg::stage_type s1_ff;
   logic                  out_valid_ff;
   i2cmws_pkg::rsp_type   out_ff, out_in;
   logic                  advance;

   assign advance = !out_valid_ff || rsp_ready;
   // buffer read data holds while stalled, since no new read is issued
   assign free    = !s1_valid_ff || advance;

   always_comb begin
      out_in = s1_ff.rsp;
      if (s1_ff.use_mem) begin
         out_in.data_byte = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (free) begin
            s1_valid_ff <= s0.valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free) begin
         s1_ff <= s0;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

/* hdl/i2c_master_write_read_sequencer.sv */
// Top level of the I2C master write-then-read sequencer.
// Depends on i2cmws_pkg, i2cmws_ram, i2cmws_ctrl and i2cmws_out.
`timescale 1ns / 1ps

// Sequences a combined write-then-read I2C transfer from the status codes of
// a byte-oriented controller. Request words either load a transmit buffer
// byte, arm a transfer (tx and rx counts, start requested), or present a
// status code with the received byte; starts and recognised events while
// armed give one action word each, everything else gives none. One request
// word is taken every clock while req_ready is high; each result word passes
// through the stage register, which covers the registered read of the
// transmit buffer RAM, and the result register. A stalled result holds the
// pipe, so req_ready drops only when both stages are full and rsp_ready is
// low. The slave address register (csr_data) is always ready and must only
// be written while no transfer word is in flight. Buffer slots must be
// loaded before they are sent; no clearing pass follows reset.
module i2c_master_write_read_sequencer #(
   parameter int TX_DEPTH = i2cmws_pkg::TX_DEPTH_DEFAULT,
   parameter int RX_MAX   = i2cmws_pkg::RX_MAX_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cmws_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmws_pkg::rsp_type rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_data
);

   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   logic                  accept;
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [7:0]            ram_wr_data;
   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [7:0]            ram_rd_data;
   i2cmws_pkg::stage_type s0;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // transmit buffer
   i2cmws_ram #(
      .WIDTH (8),
      .DEPTH (TX_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // counters and status decode; state updates as each word is taken
   i2cmws_ctrl #(
      .TX_DEPTH (TX_DEPTH),
      .RX_MAX   (RX_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_payload),
      .csr_we      (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .s0          (s0)
   );

   // buffer data merge and result register
   i2cmws_out u_out (
      .clock       (clock),
      .reset       (reset),
      .s0          (s0),
      .rd_data     (ram_rd_data),
      .free        (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // no transmit byte means an idle data field
   a_idle_data_byte : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.data_write_valid |-> rsp_payload.data_byte == 8'd0)
      else $error("data_byte set without data_write_valid");

   // a received byte always comes with an acknowledge decision
   a_rx_ack : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.rx_valid |-> rsp_payload.ack_action != i2cmws_pkg::ACK_KEEP)
      else $error("received byte without acknowledge action");

   // finishing means stop, never a new start
   a_done_stop : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.done_res |->
         rsp_payload.send_stop && !rsp_payload.set_start && rsp_payload.clear_interrupt)
      else $error("done without stop");

   // taking a request while the output is stalled is only legal with room
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && accept |=> rsp_valid)
      else $error("result lost under stall");

endmodule
